FILE: design/timer_divider_search_assert.svh
// Assertion macros for the timer divider search RTL.
`ifndef TIMER_DIVIDER_SEARCH_ASSERT_SVH
`define TIMER_DIVIDER_SEARCH_ASSERT_SVH

// Same-cycle implication, sampled on the block clock and muted during reset.
`define TDS_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the block clock and muted during reset.
`define TDS_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/tds_pkg.sv
// Shared types and constants for the timer divider search.
package tds_pkg;

   localparam int FREQ_W = 27;
   localparam int SET_W  = 16;
   localparam int DIV_W  = 2 * SET_W + 1;

   localparam logic [FREQ_W-1:0] CLOCK_RESET_HZ  = 27'd72000000;
   localparam logic [SET_W-1:0]  RELOAD_FIRST    = 16'd49;
   localparam logic [SET_W-1:0]  RELOAD_LAST     = 16'd65049;
   localparam logic [SET_W-1:0]  RELOAD_STRIDE   = 16'd1000;
   localparam logic [SET_W-1:0]  PRESCALER_START = 16'd32768;
   localparam logic [SET_W-1:0]  STEP_START      = 16'd16384;
   localparam logic [SET_W-1:0]  MAX_SETTING     = 16'hFFFF;

   typedef enum logic [1:0] {
      OUTCOME_EXACT       = 2'd0,
      OUTCOME_APPROX      = 2'd1,
      OUTCOME_UNREACHABLE = 2'd2
   } tds_outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FINISH
   } tds_state_type;

   // Request from the search controller to the divider.
   typedef struct packed {
      logic              start;
      logic [SET_W-1:0]  prescaler;
      logic [SET_W-1:0]  reload;
   } tds_div_req_type;

   // Rounded frequency returned by the divider.
   typedef struct packed {
      logic              done;
      logic [FREQ_W-1:0] freq;
   } tds_div_rsp_type;

endpackage

FILE: design/tds_divider.sv
// Bit-serial rounded divider: clock / ((1+prescaler)*(1+reload)), rounded half up.
module tds_divider import tds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [FREQ_W-1:0]   clock_hz,
   input  tds_div_req_type     div_req,
   output tds_div_rsp_type     div_rsp
);

   localparam int CNT_W = $clog2(FREQ_W + 1);

   logic              busy_ff, busy_in;
   logic              round_ff, round_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIV_W-1:0]  divisor_ff, divisor_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic [FREQ_W-1:0] dq_ff, dq_in;
   logic [FREQ_W-1:0] freq_ff, freq_in;

   logic [SET_W:0]    p_inc;
   logic [SET_W:0]    a_inc;
   logic [2*SET_W+1:0] product;
   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              fits;
   logic              round_up;

   // Divisor product, registered before the division starts.
   assign p_inc   = {1'b0, div_req.prescaler} + {{SET_W{1'b0}}, 1'b1};
   assign a_inc   = {1'b0, div_req.reload} + {{SET_W{1'b0}}, 1'b1};
   assign product = p_inc * a_inc;

   // One restoring step: shift in the next dividend bit and try a subtract.
   assign trial    = {rem_ff, dq_ff[FREQ_W-1]};
   assign diff     = trial - {1'b0, divisor_ff};
   assign fits     = trial >= {1'b0, divisor_ff};
   assign round_up = {rem_ff, 1'b0} >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      round_in   = 1'b0;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      freq_in    = freq_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = CNT_W'(FREQ_W);
         divisor_in = product[DIV_W-1:0];
         rem_in     = '0;
         dq_in      = clock_hz;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         dq_in  = {dq_ff[FREQ_W-2:0], fits};
         cnt_in = cnt_ff - {{(CNT_W-1){1'b0}}, 1'b1};
         if (cnt_ff == {{(CNT_W-1){1'b0}}, 1'b1}) begin
            busy_in  = 1'b0;
            round_in = 1'b1;
         end
      end else if (round_ff) begin
         freq_in = dq_ff + {{(FREQ_W-1){1'b0}}, round_up};
         done_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         round_ff <= 1'b0;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         busy_ff  <= busy_in;
         round_ff <= round_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      freq_ff    <= freq_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.freq = freq_ff;

endmodule

FILE: design/timer_divider_search.sv
// Top level of the timer prescaler and reload search.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  target_freq
//   rsp      out        rsp_tvalid/rsp_tready  reload, prescaler; outcome in tuser
//   csr      in         csr_valid/csr_ready    input_clock_hz
//
// Each candidate setting passes through the bit-serial divider in order: the
// divisor product, the quotient bits, rounding, then the search decision.
// A request evaluates 1 to 990 candidates.
// Reset is synchronous and restores the input clock register to 72 MHz.
// A new request is taken only when the search is idle; a finished result waits
// in the search result registers while the output register is still held.
`include "timer_divider_search_assert.svh"

module timer_divider_search import tds_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Request: [26:0] target_freq, upper bits zero.
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   // Response: [15:0] reload_value, [31:16] prescaler_value.
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   // Response: [1:0] outcome.
   output logic [1:0]          rsp_tuser,
   // Configuration: [26:0] input_clock_hz.
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FREQ_W-1:0]   csr_data
);

   tds_state_type    state_ff, state_in;
   logic [FREQ_W-1:0] clock_hz_ff;
   logic [FREQ_W-1:0] target_ff, target_in;
   logic [SET_W-1:0]  p_ff, p_in;
   logic [SET_W-1:0]  a_ff, a_in;
   logic [SET_W-1:0]  step_ff, step_in;
   logic              start_ff, start_in;
   logic [FREQ_W-1:0] best_err_ff, best_err_in;
   logic [SET_W-1:0]  best_p_ff, best_p_in;
   logic [SET_W-1:0]  best_a_ff, best_a_in;
   logic [SET_W-1:0]  res_reload_ff, res_reload_in;
   logic [SET_W-1:0]  res_prescaler_ff, res_prescaler_in;
   tds_outcome_type   res_outcome_ff, res_outcome_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SET_W-1:0]  rsp_reload_ff, rsp_reload_in;
   logic [SET_W-1:0]  rsp_prescaler_ff, rsp_prescaler_in;
   tds_outcome_type   rsp_outcome_ff, rsp_outcome_in;

   tds_div_req_type   div_req;
   tds_div_rsp_type   div_rsp;

   logic [FREQ_W-1:0] freq;
   logic [FREQ_W-1:0] err;
   logic              better;
   logic [SET_W-1:0]  p_step;

   // The configuration register takes every transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= CLOCK_RESET_HZ;
      end else if (csr_valid && csr_ready) begin
         clock_hz_ff <= csr_data;
      end
   end

   assign div_req.start     = start_ff;
   assign div_req.prescaler = p_ff;
   assign div_req.reload    = a_ff;

   tds_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .clock_hz (clock_hz_ff),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   // Error of the candidate just divided, and the next prescaler probe.
   assign freq   = div_rsp.freq;
   assign err    = (freq >= target_ff) ? (freq - target_ff) : (target_ff - freq);
   assign better = err < best_err_ff;
   assign p_step = (freq < target_ff) ? (p_ff - step_ff) : (p_ff + step_ff);

   assign req_tready = (state_ff == ST_IDLE);

   // Search sequencer: next state and register updates.
   always_comb begin
      state_in         = state_ff;
      target_in        = target_ff;
      p_in             = p_ff;
      a_in             = a_ff;
      step_in          = step_ff;
      start_in         = 1'b0;
      best_err_in      = best_err_ff;
      best_p_in        = best_p_ff;
      best_a_in        = best_a_ff;
      res_reload_in    = res_reload_ff;
      res_prescaler_in = res_prescaler_ff;
      res_outcome_in   = res_outcome_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_tready;
      rsp_reload_in    = rsp_reload_ff;
      rsp_prescaler_in = rsp_prescaler_ff;
      rsp_outcome_in   = rsp_outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               target_in   = req_tdata[FREQ_W-1:0];
               p_in        = PRESCALER_START;
               a_in        = RELOAD_FIRST;
               step_in     = STEP_START;
               best_err_in = '1;
               best_p_in   = PRESCALER_START;
               best_a_in   = RELOAD_FIRST;
               start_in    = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (div_rsp.done) begin
               if (better) begin
                  best_err_in = err;
                  best_p_in   = p_ff;
                  best_a_in   = a_ff;
               end
               if (freq == target_ff) begin
                  res_reload_in    = a_ff;
                  res_prescaler_in = p_ff;
                  res_outcome_in   = OUTCOME_EXACT;
                  state_in         = ST_FINISH;
               end else if (step_ff[0]) begin
                  // Binary search for this reload is over.
                  if (p_step < 16'd2) begin
                     res_reload_in    = best_a_in;
                     res_prescaler_in = best_p_in;
                     res_outcome_in   = OUTCOME_APPROX;
                     state_in         = ST_FINISH;
                  end else if (a_ff == RELOAD_LAST) begin
                     res_reload_in    = MAX_SETTING;
                     res_prescaler_in = MAX_SETTING;
                     res_outcome_in   = OUTCOME_UNREACHABLE;
                     state_in         = ST_FINISH;
                  end else begin
                     a_in     = a_ff + RELOAD_STRIDE;
                     p_in     = PRESCALER_START;
                     step_in  = STEP_START;
                     start_in = 1'b1;
                  end
               end else begin
                  p_in     = p_step;
                  step_in  = {1'b0, step_ff[SET_W-1:1]};
                  start_in = 1'b1;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               rsp_reload_in    = res_reload_ff;
               rsp_prescaler_in = res_prescaler_ff;
               rsp_outcome_in   = res_outcome_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search and result registers.
   always_ff @(posedge clock) begin
      target_ff        <= target_in;
      p_ff             <= p_in;
      a_ff             <= a_in;
      step_ff          <= step_in;
      best_err_ff      <= best_err_in;
      best_p_ff        <= best_p_in;
      best_a_ff        <= best_a_in;
      res_reload_ff    <= res_reload_in;
      res_prescaler_ff <= res_prescaler_in;
      res_outcome_ff   <= res_outcome_in;
      rsp_reload_ff    <= rsp_reload_in;
      rsp_prescaler_ff <= rsp_prescaler_in;
      rsp_outcome_ff   <= rsp_outcome_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_prescaler_ff, rsp_reload_ff};
   assign rsp_tuser  = rsp_outcome_ff;

   // Checks on the search sequencing.
   `TDS_ASSERT_NOW(a_done_in_eval, div_rsp.done, state_ff == ST_EVAL, "divider done outside evaluation")
   `TDS_ASSERT_NOW(a_step_onehot, state_ff == ST_EVAL, $onehot(step_ff), "search step is not one-hot")
   `TDS_ASSERT_NOW(a_prescaler_nonzero, state_ff == ST_EVAL, p_ff != '0, "prescaler probe reached zero")
   `TDS_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready, start_ff, "accepted request did not start the divider")

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the timer prescaler and reload search.
`timescale 1ns / 1ps

module tb_top;
   import tds_pkg::*;

   // One chosen timer setting, as carried by a response transfer.
   typedef struct packed {
      logic [SET_W-1:0] reload;
      logic [SET_W-1:0] prescaler;
      tds_outcome_type  outcome;
   } timer_setting_type;

   typedef enum logic {
      ROW_CLOCK,
      ROW_TARGET
   } row_kind_type;

   // A directed row either writes the clock register or sends one target.
   typedef struct packed {
      row_kind_type      kind;
      logic [FREQ_W-1:0] value;
      logic              typed;
      timer_setting_type want;
   } dir_row_type;

   // Notes whether a request carries a hand-written expectation.
   typedef struct packed {
      logic              typed;
      timer_setting_type want;
   } req_tag_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [31:0]       rsp_tdata;
   logic [1:0]        rsp_tuser;
   logic              csr_valid;
   logic              csr_ready;
   logic [FREQ_W-1:0] csr_data;

   int unsigned       send_idle_pct = 0;
   int unsigned       stall_pct = 0;
   int unsigned       error_count = 0;
   logic [FREQ_W-1:0] model_clock_hz = CLOCK_RESET_HZ;

   req_tag_type       req_tags[$];
   timer_setting_type expected_settings[$];
   dir_row_type       dir_rows[$];

   timer_divider_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Timer output frequency for one setting, rounded half up.
   function automatic logic [FREQ_W-1:0] rounded_freq(input logic [FREQ_W-1:0] clock_hz,
                                                       input logic [SET_W-1:0] prescaler,
                                                       input logic [SET_W-1:0] reload);
      logic [DIV_W:0] p_term;
      logic [DIV_W:0] r_term;
      logic [DIV_W:0] divisor;
      logic [DIV_W:0] dividend;
      logic [DIV_W:0] quotient;
      logic [DIV_W:0] remainder;
      p_term = {{(DIV_W + 1 - SET_W){1'b0}}, prescaler};
      r_term = {{(DIV_W + 1 - SET_W){1'b0}}, reload};
      divisor = (p_term + 1) * (r_term + 1);
      dividend = {{(DIV_W + 1 - FREQ_W){1'b0}}, clock_hz};
      quotient = dividend / divisor;
      remainder = dividend % divisor;
      if ((remainder << 1) >= divisor) begin
         quotient = quotient + 1;
      end
      return quotient[FREQ_W-1:0];
   endfunction

   function automatic logic [FREQ_W-1:0] freq_distance(input logic [FREQ_W-1:0] x,
                                                        input logic [FREQ_W-1:0] y);
      return (x >= y) ? x - y : y - x;
   endfunction

   // Sweeps reload and binary-searches the prescaler, keeping the closest setting.
   function automatic timer_setting_type predict_setting(input logic [FREQ_W-1:0] clock_hz,
                                                          input logic [FREQ_W-1:0] target);
      timer_setting_type best;
      logic [FREQ_W-1:0] best_err;
      logic [FREQ_W-1:0] freq;
      logic [FREQ_W-1:0] err;
      logic [SET_W:0]    reload;
      logic [SET_W:0]    prescaler;
      logic [SET_W-1:0]  step;
      best.reload = RELOAD_FIRST;
      best.prescaler = PRESCALER_START;
      best.outcome = OUTCOME_APPROX;
      best_err = freq_distance(rounded_freq(clock_hz, PRESCALER_START, RELOAD_FIRST), target);
      for (reload = {1'b0, RELOAD_FIRST}; reload <= {1'b0, RELOAD_LAST};
           reload = reload + {1'b0, RELOAD_STRIDE}) begin
         prescaler = {1'b0, PRESCALER_START};
         for (step = STEP_START; step != 0; step = step >> 1) begin
            freq = rounded_freq(clock_hz, prescaler[SET_W-1:0], reload[SET_W-1:0]);
            err = freq_distance(freq, target);
            // Only a strictly smaller error replaces the best setting.
            if (err < best_err) begin
               best_err = err;
               best.reload = reload[SET_W-1:0];
               best.prescaler = prescaler[SET_W-1:0];
            end
            if (freq == target) begin
               best.reload = reload[SET_W-1:0];
               best.prescaler = prescaler[SET_W-1:0];
               best.outcome = OUTCOME_EXACT;
               return best;
            end
            if (freq < target) begin
               prescaler = prescaler - {1'b0, step};
            end else begin
               prescaler = prescaler + {1'b0, step};
            end
         end
         // The target is above what this reload can reach.
         if (prescaler <= 1) begin
            return best;
         end
      end
      best.reload = MAX_SETTING;
      best.prescaler = MAX_SETTING;
      best.outcome = OUTCOME_UNREACHABLE;
      return best;
   endfunction

   // Targets taken from reachable settings, from the full range, or small.
   function automatic logic [FREQ_W-1:0] random_target(input logic [FREQ_W-1:0] clock_hz);
      int unsigned pick;
      logic [SET_W-1:0] reload;
      pick = $urandom_range(99);
      if (pick < 45) begin
         if (pick < 35) begin
            reload = RELOAD_FIRST
                     + SET_W'(32'(RELOAD_STRIDE) * $urandom_range(0, 65));
         end else begin
            reload = SET_W'($urandom_range(0, MAX_SETTING));
         end
         return rounded_freq(clock_hz, SET_W'($urandom_range(1, MAX_SETTING)), reload)
                + FREQ_W'($urandom_range(0, 2)) - FREQ_W'(1);
      end else if (pick < 70) begin
         return FREQ_W'($urandom);
      end
      return FREQ_W'($urandom & ((32'd1 << $urandom_range(0, FREQ_W - 1)) - 1));
   endfunction

   function automatic dir_row_type make_row(input row_kind_type kind,
                                            input logic [FREQ_W-1:0] value,
                                            input logic typed, input logic [SET_W-1:0] reload,
                                            input logic [SET_W-1:0] prescaler,
                                            input tds_outcome_type outcome);
      dir_row_type row;
      row.kind = kind;
      row.value = value;
      row.typed = typed;
      row.want.reload = reload;
      row.want.prescaler = prescaler;
      row.want.outcome = outcome;
      return row;
   endfunction

   // Offers one target and returns once its transfer has happened.
   task automatic send_target(input logic [FREQ_W-1:0] target, input logic typed,
                              input timer_setting_type want);
      req_tag_type tag;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      tag.typed = typed;
      tag.want = want;
      req_tags.push_back(tag);
      req_tvalid <= 1'b1;
      req_tdata <= {{(32 - FREQ_W){1'b0}}, target};
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (req_tags.size() != 0 || expected_settings.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_clock(input logic [FREQ_W-1:0] hz);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= hz;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // The receiver stalls at random at the rate of the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Tracks the clock register, predicts or takes the expectation of each accepted target and checks responses.
   always @(posedge clock) begin : monitor
      timer_setting_type want;
      req_tag_type       tag;
      if (reset) begin
         model_clock_hz = CLOCK_RESET_HZ;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_settings.size() == 0) begin
               $error("response transfer with no request outstanding");
               error_count++;
            end else begin
               want = expected_settings.pop_front();
               if (rsp_tdata[15:0] !== want.reload) begin
                  $error("reload_value mismatch: expected %0d, actual %0d",
                         want.reload, rsp_tdata[15:0]);
                  error_count++;
               end
               if (rsp_tdata[31:16] !== want.prescaler) begin
                  $error("prescaler_value mismatch: expected %0d, actual %0d",
                         want.prescaler, rsp_tdata[31:16]);
                  error_count++;
               end
               if (rsp_tuser !== want.outcome) begin
                  $error("outcome mismatch: expected %0d, actual %0d",
                         want.outcome, rsp_tuser);
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            model_clock_hz = csr_data;
         end
         if (req_tvalid && req_tready) begin
            tag = req_tags.pop_front();
            if (tag.typed) begin
               expected_settings.push_back(tag.want);
            end else begin
               expected_settings.push_back(predict_setting(model_clock_hz,
                                                           req_tdata[FREQ_W-1:0]));
            end
         end
      end
   end

   // Stimulus: directed rows first, then four random phases with different idling and stalling.
   initial begin
      dir_row_type       row;
      logic [FREQ_W-1:0] phase_hz[4];
      int unsigned       phase_idle[4];
      int unsigned       phase_stall[4];
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset clock: targets beyond reach, the first candidate hit, small and odd values.
      dir_rows.push_back(make_row(ROW_TARGET, 27'h7FFFFFF, 1'b1, 16'd49, 16'd2,
                                  OUTCOME_APPROX));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd44, 1'b1, RELOAD_FIRST, PRESCALER_START,
                                  OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd0, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd1, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd480000, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd720000, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd440, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'h5555555, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'h2AAAAAA, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd12345, 1'b0, '0, '0, OUTCOME_EXACT));
      // Top of the clock range.
      dir_rows.push_back(make_row(ROW_CLOCK, 27'd100000000, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd100000000, 1'b1, 16'd49, 16'd2,
                                  OUTCOME_APPROX));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd440, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd1000000, 1'b0, '0, '0, OUTCOME_EXACT));
      // A 1 Hz clock rounds every candidate to zero.
      dir_rows.push_back(make_row(ROW_CLOCK, 27'd1, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd0, 1'b1, RELOAD_FIRST, PRESCALER_START,
                                  OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd1, 1'b1, RELOAD_FIRST, PRESCALER_START,
                                  OUTCOME_APPROX));
      // A zero clock register keeps the initial best setting.
      dir_rows.push_back(make_row(ROW_CLOCK, 27'd0, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd0, 1'b1, RELOAD_FIRST, PRESCALER_START,
                                  OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'h7FFFFFF, 1'b1, RELOAD_FIRST,
                                  PRESCALER_START, OUTCOME_APPROX));
      // All register bits set, beyond the nominal range.
      dir_rows.push_back(make_row(ROW_CLOCK, 27'h7FFFFFF, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd0, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'd1, 1'b0, '0, '0, OUTCOME_EXACT));
      dir_rows.push_back(make_row(ROW_TARGET, 27'h7FFFFFF, 1'b0, '0, '0, OUTCOME_EXACT));

      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         if (row.kind == ROW_CLOCK) begin
            req_tvalid <= 1'b0;
            wait_drained();
            write_clock(row.value);
         end else begin
            send_target(row.value, row.typed, row.want);
         end
      end

      // Random phases: none, sender idle, receiver stalling, both.
      phase_hz[0] = CLOCK_RESET_HZ;
      phase_hz[1] = FREQ_W'($urandom_range(1, 100000000));
      phase_hz[2] = FREQ_W'($urandom_range(1000, 1000000));
      phase_hz[3] = FREQ_W'($urandom);
      phase_idle[0] = 0;
      phase_idle[1] = 63;
      phase_idle[2] = 0;
      phase_idle[3] = 25;
      phase_stall[0] = 0;
      phase_stall[1] = 0;
      phase_stall[2] = 63;
      phase_stall[3] = 25;
      for (int phase = 0; phase < 4; phase++) begin
         req_tvalid <= 1'b0;
         wait_drained();
         send_idle_pct = phase_idle[phase];
         stall_pct = phase_stall[phase];
         write_clock(phase_hz[phase]);
         repeat (20) begin
            send_target(random_target(phase_hz[phase]), 1'b0, '0);
         end
      end

      // Drain, then allow a few more cycles for any stray response transfer.
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // The timeout allows several times the slowest run, a full sweep of candidates.
   initial begin
      #200000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/tds_pkg.sv
design/tds_divider.sv
design/timer_divider_search.sv
test/tb_top.sv
